### hw/rtl/pbd_pkg.sv
package pbd_pkg;

   localparam int PIX_W          = 8;
   localparam int NUM_CHAN       = 4;
   localparam int ALPHA_CHAN     = 3;
   localparam int MAX_OUT_HEIGHT = 1024;
   localparam int ROW_W          = 10;
   localparam int QUO_STEPS      = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SIZE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA  = 2'd3;

   localparam logic [10:0] OUT_WIDTH_RST  = 11'd1;
   localparam logic [10:0] OUT_HEIGHT_RST = 11'd1;
   localparam logic [4:0]  BIN_SIZE_RST   = 5'd2;
   localparam logic        HAS_ALPHA_RST  = 1'b1;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_pix_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_end;
   } rsp_pix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage

### hw/rtl/pixel_binning_downsampler.sv
// Box-filter downsampler: source pixels arrive in raster order, bin_size * out_width per
// row and bin_size * out_height rows per frame, and each bin_size x bin_size block gives
// one output pixel holding the truncated per-channel mean (alpha forced to zero in RGB
// mode). frame_end marks the last output of a frame; any register write restarts the
// frame. Partial block sums live in a single-port line store of MAX_OUT_WIDTH entries,
// one per output column, read on the cycle a pixel is taken and written back on the next;
// no new source pixel is taken until the write-back is done. A pixel that closes a block
// then runs a restoring division (one quotient bit per cycle, all four channels side by
// side) and loads the output register, waiting while an earlier result is still stalled on
// the output, before the next pixel is taken. The line store needs no clearing after reset.
module pixel_binning_downsampler #(
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_BIN       = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pbd_pkg::req_pix_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pbd_pkg::rsp_pix_type                   rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [pbd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]         csr_write_data
);
   import pbd_pkg::*;

   localparam int COL_W   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int WX_W    = ($clog2(MAX_OUT_WIDTH + 1) > 11) ? $clog2(MAX_OUT_WIDTH + 1) : 11;
   localparam int BCNT_W  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
   localparam int BIN_W   = $clog2(MAX_BIN + 1);
   localparam int BX_W    = (BIN_W > 5) ? BIN_W : 5;
   localparam int AREA_W  = $clog2(MAX_BIN * MAX_BIN + 1);
   localparam int SUM_W   = $clog2(255 * MAX_BIN * MAX_BIN + 1);
   localparam int DV_W    = AREA_W + QUO_STEPS - 1;
   localparam int CMP_W   = AREA_W + QUO_STEPS;
   localparam int MEM_W   = NUM_CHAN * SUM_W;

   // configuration
   logic [10:0] out_width_ff;
   logic [10:0] out_height_ff;
   logic [4:0]  bin_size_ff;
   logic        has_alpha_ff;

   // effective geometry
   logic [WX_W-1:0]   width_ext;
   logic [BX_W-1:0]   bin_ext;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;
   logic [BCNT_W-1:0] b_last;
   logic [BIN_W-1:0]  b_eff;
   logic [AREA_W-1:0] area_ff;

   // raster counters
   logic [BCNT_W-1:0] col_blk_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [BCNT_W-1:0] row_blk_ff;
   logic [ROW_W-1:0]  out_row_ff;

   state_type state_ff;
   state_type state_in;

   logic req_take;
   logic rsp_take;
   logic mem_we;
   logic div_load;
   logic rsp_load;

   // item in flight
   logic [PIX_W-1:0] pix_ff [NUM_CHAN];
   logic [COL_W-1:0] addr_ff;
   logic             first_ff;
   logic             last_ff;
   logic             frame_last_ff;

   logic [MEM_W-1:0] sums_mem [MAX_OUT_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] wr_data;
   logic [SUM_W-1:0] sum_new [NUM_CHAN];

   // divider lanes
   logic [SUM_W-1:0] rem_ff [NUM_CHAN];
   logic [7:0]       quo_ff [NUM_CHAN];
   logic [DV_W-1:0]  dvs_ff;
   logic [2:0]       div_cnt_ff;

   logic        rsp_valid_ff;
   rsp_pix_type rsp_data_ff;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- geometry
   always_comb begin
      width_ext = WX_W'(out_width_ff);
      bin_ext   = BX_W'(bin_size_ff);
      if (width_ext == '0) begin
         w_last = '0;
      end else if (width_ext > WX_W'(MAX_OUT_WIDTH)) begin
         w_last = COL_W'(MAX_OUT_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ext - WX_W'(1));
      end
      if (out_height_ff == '0) begin
         h_last = '0;
      end else if (out_height_ff > 11'(MAX_OUT_HEIGHT)) begin
         h_last = ROW_W'(MAX_OUT_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(out_height_ff - 11'd1);
      end
      if (bin_ext == '0) begin
         b_last = '0;
      end else if (bin_ext > BX_W'(MAX_BIN)) begin
         b_last = BCNT_W'(MAX_BIN - 1);
      end else begin
         b_last = BCNT_W'(bin_ext - BX_W'(1));
      end
      b_eff = BIN_W'(b_last) + BIN_W'(1);
   end

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(b_eff) * AREA_W'(b_eff);
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= OUT_WIDTH_RST;
         out_height_ff <= OUT_HEIGHT_RST;
         bin_size_ff   <= BIN_SIZE_RST;
         has_alpha_ff  <= HAS_ALPHA_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OUT_WIDTH:  out_width_ff  <= csr_write_data;
            CSR_OUT_HEIGHT: out_height_ff <= csr_write_data;
            CSR_BIN_SIZE:   bin_size_ff   <= csr_write_data[4:0];
            CSR_HAS_ALPHA:  has_alpha_ff  <= csr_write_data[0];
            default:        has_alpha_ff  <= has_alpha_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- counters
   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         col_blk_ff <= '0;
         out_col_ff <= '0;
         row_blk_ff <= '0;
         out_row_ff <= '0;
      end else if (req_take) begin
         if (col_blk_ff == b_last) begin
            col_blk_ff <= '0;
            if (out_col_ff == w_last) begin
               out_col_ff <= '0;
               if (row_blk_ff == b_last) begin
                  row_blk_ff <= '0;
                  out_row_ff <= (out_row_ff == h_last) ? '0 : out_row_ff + ROW_W'(1);
               end else begin
                  row_blk_ff <= row_blk_ff + BCNT_W'(1);
               end
            end else begin
               out_col_ff <= out_col_ff + COL_W'(1);
            end
         end else begin
            col_blk_ff <= col_blk_ff + BCNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      mem_we    = 1'b0;
      div_load  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            mem_we = 1'b1;
            if (last_ff) begin
               div_load = 1'b1;
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_cnt_ff == 3'(QUO_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff[0]     <= req_data.in_red;
         pix_ff[1]     <= req_data.in_green;
         pix_ff[2]     <= req_data.in_blue;
         pix_ff[3]     <= has_alpha_ff ? req_data.in_alpha : '0;
         addr_ff       <= out_col_ff;
         first_ff      <= (row_blk_ff == '0) && (col_blk_ff == '0);
         last_ff       <= (row_blk_ff == b_last) && (col_blk_ff == b_last);
         frame_last_ff <= (row_blk_ff == b_last) && (col_blk_ff == b_last)
                          && (out_col_ff == w_last) && (out_row_ff == h_last);
      end
   end

   // ---------------------------------------------------------------- line store
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum_new[c] = first_ff ? SUM_W'(pix_ff[c])
                               : rd_data_ff[c*SUM_W +: SUM_W] + SUM_W'(pix_ff[c]);
         wr_data[c*SUM_W +: SUM_W] = sum_new[c];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[addr_ff] <= wr_data;
      end
      if (req_take) begin
         rd_data_ff <= sums_mem[out_col_ff];
      end
   end

   // ---------------------------------------------------------------- divider
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (div_load) begin
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIVIDE) begin
         div_cnt_ff <= div_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         dvs_ff <= DV_W'(area_ff) << (QUO_STEPS - 1);
         for (int c = 0; c < NUM_CHAN; c++) begin
            rem_ff[c] <= sum_new[c];
            quo_ff[c] <= '0;
         end
      end else if (state_ff == ST_DIVIDE) begin
         dvs_ff <= dvs_ff >> 1;
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (CMP_W'(rem_ff[c]) >= CMP_W'(dvs_ff)) begin
               rem_ff[c] <= rem_ff[c] - SUM_W'(dvs_ff);
               quo_ff[c] <= {quo_ff[c][6:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_red   <= quo_ff[0];
         rsp_data_ff.out_green <= quo_ff[1];
         rsp_data_ff.out_blue  <= quo_ff[2];
         rsp_data_ff.out_alpha <= has_alpha_ff ? quo_ff[ALPHA_CHAN] : '0;
         rsp_data_ff.frame_end <= frame_last_ff;
      end
   end

`ifndef SYNTHESIS
   // the divide only ever follows a read-modify-write of a closing pixel
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && ($past(state_ff) != ST_DIVIDE)
      |-> ($past(state_ff) == ST_UPDATE) && $past(last_ff))
      else $error("divide entered without a closing pixel");

   // a finished quotient leaves a remainder below the block area
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD)
      |-> (CMP_W'(rem_ff[0]) < CMP_W'(area_ff)) && (CMP_W'(rem_ff[1]) < CMP_W'(area_ff))
          && (CMP_W'(rem_ff[2]) < CMP_W'(area_ff)) && (CMP_W'(rem_ff[3]) < CMP_W'(area_ff)))
      else $error("quotient overflowed its eight bits");

   // raster counters stay inside the effective geometry
   assert property (@(posedge clock) disable iff (reset)
      (col_blk_ff <= b_last) && (row_blk_ff <= b_last)
      && (out_col_ff <= w_last) && (out_row_ff <= h_last))
      else $error("raster counter outside geometry");

   // a new result is loaded only when the previous one has gone
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result overwritten before transfer");
`endif

endmodule
